FILE: src/least_work_queue_dispatcher_core_assert.svh
// Assertion macros shared by the dispatcher RTL.
// Depends on the including module providing aclk and aresetn.
`ifndef LEAST_WORK_QUEUE_DISPATCHER_CORE_ASSERT_SVH
`define LEAST_WORK_QUEUE_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LWQD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LWQD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

FILE: src/lwqd_pkg.sv
// Package for the least-work queue dispatcher: sizes, types and codes.
// Used by the dispatcher core and lwqd_select; depends on nothing.
`timescale 1ns / 1ps

package lwqd_pkg;

    localparam int QUEUES      = 5;
    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_WORK    = 255;

    localparam int QIDX_W  = $clog2(QUEUES);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int WORK_W  = $clog2(QUEUE_DEPTH * MAX_WORK + 1);
    localparam int ENTRIES = QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam logic FUNC_ARRIVAL  = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    typedef logic [QIDX_W-1:0] qidx_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [WORK_W-1:0] work_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [7:0] requester;
        logic [7:0] work;
    } entry_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Flat entry address of a slot inside a queue's region.
    function automatic addr_t slot_addr(qidx_t q, ptr_t p);
        slot_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic ptr_t ptr_inc(ptr_t p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

FILE: src/lwqd_entry_ram.sv
// Generic simple dual-port RAM with a registered read port.
// Holds the queued entries; no package dependency.
`timescale 1ns / 1ps

module lwqd_entry_ram #(
    parameter int DEPTH = 160,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/lwqd_select.sv
// Finds the queue with the smallest pending work, lowest index on ties.
// Depends on lwqd_pkg.
`timescale 1ns / 1ps

module lwqd_select
    import lwqd_pkg::*;
(
    input  work_t pending [QUEUES],
    output qidx_t best
);

    always_comb begin
        work_t min_w;
        best  = '0;
        min_w = pending[0];
        for (int i = 1; i < QUEUES; i++) begin
            if (pending[i] < min_w) begin
                best  = QIDX_W'(i);
                min_w = pending[i];
            end
        end
    end

endmodule

FILE: src/least_work_queue_dispatcher_core.sv
// Least-work queue dispatcher. Takes one request per clock unless the result side stalls, and
// returns one result per request: a request is first captured in an input register (the
// entry memory read for a completion is issued in that same cycle), then the queue choice
// and state update are done in one pass into the result register. An arrival joins the
// queue with the least pending work (lowest index on ties); a completion pops the oldest
// entry of the named queue. The entry store is a 160 x 16 bit memory with one write and one
// read port; it is not cleared after reset, since data that a completion reads from an
// empty queue is never used.
`timescale 1ns / 1ps
`include "least_work_queue_dispatcher_core_assert.svh"

module least_work_queue_dispatcher_core
    import lwqd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_requester_id,
    input  logic [7:0] s_work_amount,
    input  logic [2:0] s_served_queue,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_queue_index,
    output logic [7:0] m_out_requester_id,
    output logic [7:0] m_out_work_amount,
    output logic [12:0] m_queue_work_after,
    output logic [1:0] m_status
);

    // Queue state.
    work_t pend_reg [QUEUES];
    work_t pend_next [QUEUES];
    ptr_t  wp_reg [QUEUES];
    ptr_t  wp_next [QUEUES];
    ptr_t  rp_reg [QUEUES];
    ptr_t  rp_next [QUEUES];
    cnt_t  cnt_reg [QUEUES];
    cnt_t  cnt_next [QUEUES];

    // Input stage.
    logic       b_valid_reg;
    logic       func_reg;
    logic [7:0] id_reg;
    logic [7:0] work_reg;
    logic [2:0] sq_reg;
    logic       fwd_reg;
    entry_t     fwd_data_reg;

    // Result stage.
    logic       m_valid_reg;
    logic [2:0] q_out_reg;
    logic [7:0] id_out_reg;
    logic [7:0] work_out_reg;
    logic [12:0] after_out_reg;
    status_t    status_reg;

    logic [2:0] q_out_next;
    logic [7:0] id_out_next;
    logic [7:0] work_out_next;
    logic [12:0] after_out_next;
    status_t    status_next;

    qidx_t  best;
    qidx_t  qsel;
    logic   sq_ok;
    logic   b_adv;
    logic   s_acc;
    logic   sel_full;
    logic   sel_empty;
    logic   push;
    logic   pop;
    work_t  pend_sel;
    cnt_t   cnt_sel;
    entry_t pop_entry;
    entry_t ram_rdata;
    entry_t push_entry;
    addr_t  waddr;
    addr_t  raddr;
    logic   rd_en;
    logic   in_sq_ok;
    qidx_t  in_q;
    logic   fwd_next;

    lwqd_select u_select (
        .pending (pend_reg),
        .best    (best)
    );

    assign b_adv   = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !b_valid_reg || b_adv;
    assign s_acc   = s_valid && s_ready;

    assign sq_ok = 32'(sq_reg) < QUEUES;
    assign qsel  = (func_reg == FUNC_ARRIVAL) ? best : QIDX_W'(sq_reg);

    always_comb begin
        pend_sel = '0;
        cnt_sel  = '0;
        if (func_reg == FUNC_ARRIVAL || sq_ok) begin
            pend_sel = pend_reg[qsel];
            cnt_sel  = cnt_reg[qsel];
        end
    end

    assign sel_full  = cnt_sel == CNT_W'(QUEUE_DEPTH);
    assign sel_empty = cnt_sel == '0;
    assign push = b_adv && func_reg == FUNC_ARRIVAL && !sel_full;
    assign pop  = b_adv && func_reg == FUNC_COMPLETE && sq_ok && !sel_empty;

    // A completion read issued when the request was accepted may target the slot
    // written by the arrival that was in flight at the time; that data comes from the bypass.
    assign pop_entry  = fwd_reg ? fwd_data_reg : ram_rdata;
    assign push_entry = '{requester: id_reg, work: work_reg};

    always_comb begin
        for (int i = 0; i < QUEUES; i++) begin
            pend_next[i] = pend_reg[i];
            wp_next[i]   = wp_reg[i];
            rp_next[i]   = rp_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (push && qsel == QIDX_W'(i)) begin
                pend_next[i] = pend_reg[i] + WORK_W'(work_reg);
                wp_next[i]   = ptr_inc(wp_reg[i]);
                cnt_next[i]  = cnt_reg[i] + CNT_W'(1);
            end
            if (pop && qsel == QIDX_W'(i)) begin
                pend_next[i] = (pend_reg[i] >= WORK_W'(pop_entry.work))
                             ? pend_reg[i] - WORK_W'(pop_entry.work) : '0;
                rp_next[i]   = ptr_inc(rp_reg[i]);
                cnt_next[i]  = cnt_reg[i] - CNT_W'(1);
            end
        end
    end

    always_comb begin
        q_out_next     = (func_reg == FUNC_ARRIVAL) ? 3'(best) : sq_reg;
        id_out_next    = '0;
        work_out_next  = '0;
        after_out_next = '0;
        status_next    = STATUS_OK;
        if (func_reg == FUNC_ARRIVAL) begin
            id_out_next   = id_reg;
            work_out_next = work_reg;
            if (sel_full) begin
                after_out_next = 13'(pend_sel);
                status_next    = STATUS_FULL;
            end else begin
                after_out_next = 13'(pend_sel + WORK_W'(work_reg));
            end
        end else if (!sq_ok) begin
            status_next = STATUS_EMPTY;
        end else if (sel_empty) begin
            after_out_next = 13'(pend_sel);
            status_next    = STATUS_EMPTY;
        end else begin
            id_out_next    = pop_entry.requester;
            work_out_next  = pop_entry.work;
            after_out_next = 13'((pend_sel >= WORK_W'(pop_entry.work))
                           ? pend_sel - WORK_W'(pop_entry.work) : '0);
        end
    end

    // Memory read for an incoming completion uses the read pointer as it will
    // stand after the request now in the input stage is applied.
    assign in_sq_ok = 32'(s_served_queue) < QUEUES;
    assign in_q     = QIDX_W'(s_served_queue);
    assign rd_en    = s_acc && s_func == FUNC_COMPLETE && in_sq_ok;
    assign raddr    = in_sq_ok ? slot_addr(in_q, rp_next[in_q]) : '0;
    assign waddr    = slot_addr(qsel, wp_reg[qsel]);
    assign fwd_next = push && raddr == waddr;

    lwqd_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(entry_t))
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (waddr),
        .wdata (push_entry),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUES; i++) begin
                pend_reg[i] <= '0;
                wp_reg[i]   <= '0;
                rp_reg[i]   <= '0;
                cnt_reg[i]  <= '0;
            end
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            cnt_reg  <= cnt_next;
            if (s_ready) begin
                b_valid_reg <= s_valid;
            end
            if (b_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            func_reg     <= s_func;
            id_reg       <= s_requester_id;
            work_reg     <= s_work_amount;
            sq_reg       <= s_served_queue;
            fwd_reg      <= rd_en && fwd_next;
            fwd_data_reg <= push_entry;
        end
        if (b_adv) begin
            q_out_reg     <= q_out_next;
            id_out_reg    <= id_out_next;
            work_out_reg  <= work_out_next;
            after_out_reg <= after_out_next;
            status_reg    <= status_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_queue_index      = q_out_reg;
    assign m_out_requester_id = id_out_reg;
    assign m_out_work_amount  = work_out_reg;
    assign m_queue_work_after = after_out_reg;
    assign m_status           = status_reg;

    `LWQD_ASSERT_IMP(a_cnt_bound, b_valid_reg, cnt_sel <= CNT_W'(QUEUE_DEPTH))
    `LWQD_ASSERT_IMP(a_push_pop_excl, 1'b1, !(push && pop))
    `LWQD_ASSERT_NXT(a_push_result, push, m_valid && m_status == STATUS_OK)
    `LWQD_ASSERT_IMP(a_empty_zero, m_valid && m_status == STATUS_EMPTY,
        m_out_requester_id == 8'd0 && m_out_work_amount == 8'd0)

endmodule
